/* sv/lik_pkg.sv */
`timescale 1ns / 1ps
// Shared package for the two-link arm inverse kinematics pipeline.
// Holds fixed-point formats, CORDIC tables, register indexes and payload types; no dependencies.
package lik_pkg;

   // Q16.16 coordinates, Q30 radians for angles
   localparam int FRAC_BITS     = 16;
   localparam int GAIN_FRAC     = 30;
   localparam int ROT_SHIFT     = GAIN_FRAC - FRAC_BITS;
   localparam int CORDIC_STAGES = 16;

   // datapath widths of the CORDIC units
   localparam int VEC_W = 50;
   localparam int ANG_W = 35;

   // square root: one result bit per stage
   localparam int SQRT_STEPS = 32;

   // vectoring normalizer: two binary shift steps per stage, top bit lands at NORM_TOP
   localparam int NORM_STAGES = 3;
   localparam int NORM_STEPS  = 2 * NORM_STAGES;
   localparam int NORM_TOP    = 46;
   localparam int VEC_LAT     = NORM_STAGES + CORDIC_STAGES;

   localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd3373259426);
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1686629713);
   localparam logic [29:0]             GAIN_INV    = 30'd652032874;

   // atan(2^-i) in Q30, truncated (the last four entries are rounded up)
   localparam logic [31:0] ATAN_TAB [0:30] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001
   };

   localparam logic [30:0] SEG_RESET = 31'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      CSR_BASE_X       = 3'd0,
      CSR_BASE_Y       = 3'd1,
      CSR_FIRST_LEN    = 3'd2,
      CSR_SECOND_LEN   = 3'd3,
      CSR_ELBOW_REV    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] elbow_x;
      logic signed [31:0] elbow_y;
      logic signed [31:0] tip_x;
      logic signed [31:0] tip_y;
      logic               reachable;
   } rsp_type;

endpackage

/* sv/lik_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined 64-bit integer square root, floor(sqrt(v)), one result bit per stage.
// Depends on lik_pkg for the stage count.
module lik_sqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] value_in,
   output logic [31:0] root_out
);

   logic [63:0] rem_ff  [lik_pkg::SQRT_STEPS];
   logic [63:0] root_ff [lik_pkg::SQRT_STEPS];

   for (genvar i = 0; i < lik_pkg::SQRT_STEPS; i++) begin : g_step
      localparam logic [63:0] STEP_BIT = 64'd1 << (2 * (lik_pkg::SQRT_STEPS - 1 - i));
      logic [63:0] rem_src;
      logic [63:0] root_src;
      logic [63:0] trial;
      logic [63:0] rem_in;
      logic [63:0] root_in;

      if (i == 0) begin : g_first
         assign rem_src  = value_in;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      // try to subtract the next odd term
      always_comb begin
         trial = root_src + STEP_BIT;
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = (root_src >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_src;
            root_in = root_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
         end
      end
   end

   assign root_out = root_ff[lik_pkg::SQRT_STEPS-1][31:0];

endmodule

/* sv/lik_vector.sv */
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: angle of (x, y) with x >= 0, Q30 radians.
// Normalizer stages then one CORDIC iteration per stage; depends on lik_pkg.
module lik_vector (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [lik_pkg::VEC_W-1:0] x_in,
   input  logic signed [lik_pkg::VEC_W-1:0] y_in,
   output logic signed [lik_pkg::ANG_W-1:0] angle_out
);

   typedef struct packed {
      logic signed [lik_pkg::VEC_W-1:0] x;
      logic signed [lik_pkg::VEC_W-1:0] y;
      logic [lik_pkg::NORM_TOP:0]       m;
   } norm_type;

   // two binary normalize steps: shift when the magnitude has room for it
   function automatic norm_type norm_pair(norm_type n, int unsigned first);
      norm_type    r;
      int unsigned sh;
      r = n;
      for (int k = 0; k < 2; k++) begin
         sh = first >> k;
         if ((r.m >> (lik_pkg::NORM_TOP + 1 - sh)) == '0) begin
            r.m = r.m << sh;
            r.x = r.x <<< sh;
            r.y = r.y <<< sh;
         end
      end
      return r;
   endfunction

   norm_type                         norm_ff [lik_pkg::NORM_STAGES];
   logic signed [lik_pkg::VEC_W-1:0] cx_ff   [lik_pkg::CORDIC_STAGES];
   logic signed [lik_pkg::VEC_W-1:0] cy_ff   [lik_pkg::CORDIC_STAGES];
   logic signed [lik_pkg::ANG_W-1:0] ca_ff   [lik_pkg::CORDIC_STAGES];

   logic signed [lik_pkg::VEC_W-1:0] abs_y;
   norm_type                         norm_start;

   // magnitude bound for the shift search
   always_comb begin
      abs_y        = y_in[lik_pkg::VEC_W-1] ? -y_in : y_in;
      norm_start.x = x_in;
      norm_start.y = y_in;
      norm_start.m = (lik_pkg::NORM_TOP + 1)'(x_in) | (lik_pkg::NORM_TOP + 1)'(abs_y);
   end

   for (genvar j = 0; j < lik_pkg::NORM_STAGES; j++) begin : g_norm
      localparam int unsigned FIRST_SHIFT = 1 << (lik_pkg::NORM_STEPS - 1 - 2 * j);
      norm_type src;
      if (j == 0) begin : g_first
         assign src = norm_start;
      end else begin : g_next
         assign src = norm_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            norm_ff[j] <= norm_pair(src, FIRST_SHIFT);
         end
      end
   end

   for (genvar i = 0; i < lik_pkg::CORDIC_STAGES; i++) begin : g_iter
      logic signed [lik_pkg::VEC_W-1:0] xi;
      logic signed [lik_pkg::VEC_W-1:0] yi;
      logic signed [lik_pkg::ANG_W-1:0] ai;
      logic signed [lik_pkg::ANG_W-1:0] step_ang;

      assign step_ang = $signed(lik_pkg::ANG_W'(lik_pkg::ATAN_TAB[i]));

      if (i == 0) begin : g_first
         assign xi = norm_ff[lik_pkg::NORM_STAGES-1].x;
         assign yi = norm_ff[lik_pkg::NORM_STAGES-1].y;
         assign ai = '0;
      end else begin : g_next
         assign xi = cx_ff[i-1];
         assign yi = cy_ff[i-1];
         assign ai = ca_ff[i-1];
      end

      // rotate toward the x axis
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!yi[lik_pkg::VEC_W-1]) begin
               cx_ff[i] <= xi + (yi >>> i);
               cy_ff[i] <= yi - (xi >>> i);
               ca_ff[i] <= ai + step_ang;
            end else begin
               cx_ff[i] <= xi - (yi >>> i);
               cy_ff[i] <= yi + (xi >>> i);
               ca_ff[i] <= ai - step_ang;
            end
         end
      end
   end

   assign angle_out = ca_ff[lik_pkg::CORDIC_STAGES-1];

endmodule

/* sv/two_link_arm_inverse_kinematics.sv */
`timescale 1ns / 1ps
// Two-link planar arm inverse kinematics, top level: offset, square roots, angles, elbow rotation.
// Depends on lik_pkg, lik_sqrt and lik_vector.
//
// One target point enters per cycle unless a result is held by a stall; most of the depth
// comes from the two 32-stage square roots, the 19-stage vectoring CORDICs (run side by side)
// and the 16-stage rotation CORDIC. A stall on the result channel freezes the whole pipeline,
// so the request side sees stall exactly while a result waits to be taken. Configuration
// writes are always taken (csr_ready high) and must only be issued while the pipeline is empty.
module two_link_arm_inverse_kinematics (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lik_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lik_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  lik_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data
);

   localparam int SQ  = lik_pkg::SQRT_STEPS;
   localparam int VL  = lik_pkg::VEC_LAT;
   localparam int CS  = lik_pkg::CORDIC_STAGES;
   localparam int VW  = lik_pkg::VEC_W;
   localparam int AW  = lik_pkg::ANG_W;
   localparam logic signed [VW-1:0] ROUND_BIAS = VW'(64'sd1 <<< (lik_pkg::ROT_SHIFT - 1));
   localparam logic signed [VW-1:0] SAT_HI     = VW'((64'sd1 <<< 31) - 64'sd1);
   localparam logic signed [VW-1:0] SAT_LO     = -SAT_HI - VW'(1);

   typedef enum logic [1:0] {ANG_ZERO, ANG_HALF, ANG_CORDIC} ang_mode_type;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic               ge;
   } sq_ctx_type;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic               reach;
      ang_mode_type       a1_mode;
      ang_mode_type       a2_mode;
   } vc_ctx_type;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic               reach;
      logic               flip;
   } rot_ctx_type;

   function automatic logic signed [31:0] sat33(logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'sh80000000 : 32'sh7fffffff;
      end
      return v[31:0];
   endfunction

   // round off the gain fraction, undo the half-turn fold, clamp to 32 bits
   function automatic logic signed [31:0] round_sat(logic signed [VW-1:0] v, logic flip);
      logic signed [VW-1:0] r;
      r = (v + ROUND_BIAS) >>> lik_pkg::ROT_SHIFT;
      if (flip) begin
         r = -r;
      end
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[31:0];
   endfunction

   logic advance;

   // configuration registers
   logic signed [31:0] base_x_ff;
   logic signed [31:0] base_y_ff;
   logic [30:0]        l1_ff;
   logic [30:0]        l2_ff;
   logic               rev_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
         l1_ff     <= lik_pkg::SEG_RESET;
         l2_ff     <= lik_pkg::SEG_RESET;
         rev_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            lik_pkg::CSR_BASE_X:     base_x_ff <= csr_data;
            lik_pkg::CSR_BASE_Y:     base_y_ff <= csr_data;
            lik_pkg::CSR_FIRST_LEN:  l1_ff     <= csr_data[30:0];
            lik_pkg::CSR_SECOND_LEN: l2_ff     <= csr_data[30:0];
            lik_pkg::CSR_ELBOW_REV:  rev_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // hold every stage while a result waits on the output
   logic             rsp_valid_ff;
   lik_pkg::rsp_type rsp_data_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 1: saturated offset from the base
   logic               v1_ff;
   logic signed [31:0] dx1_ff, dy1_ff;
   logic signed [32:0] diff_x, diff_y;

   assign diff_x = $signed({req_data.target_x[31], req_data.target_x})
                 - $signed({base_x_ff[31], base_x_ff});
   assign diff_y = $signed({req_data.target_y[31], req_data.target_y})
                 - $signed({base_y_ff[31], base_y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx1_ff <= sat33(diff_x);
         dy1_ff <= sat33(diff_y);
      end
   end

   // stage 2: squares and (2*L1)^2
   logic               v2_ff;
   logic signed [63:0] sq_x_full, sq_y_full;
   logic [63:0]        fl_full;
   logic [31:0]        l1_twice;
   logic [63:0]        sqx2_ff, sqy2_ff, fl2_ff;
   logic signed [31:0] dx2_ff, dy2_ff;

   assign sq_x_full = dx1_ff * dx1_ff;
   assign sq_y_full = dy1_ff * dy1_ff;
   assign l1_twice  = {l1_ff, 1'b0};
   assign fl_full   = l1_twice * l1_twice;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx2_ff <= sq_x_full;
         sqy2_ff <= sq_y_full;
         fl2_ff  <= fl_full;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
      end
   end

   // stage 3: squared distance
   logic               v3_ff;
   logic [63:0]        q3_ff, fl3_ff;
   logic signed [31:0] dx3_ff, dy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q3_ff  <= sqx2_ff + sqy2_ff;
         fl3_ff <= fl2_ff;
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
      end
   end

   // stage 4: first-segment reach test and remainder under the elbow root
   logic               v4_ff;
   logic               ge4_ff;
   logic [63:0]        q4_ff, rem4_ff;
   logic signed [31:0] dx4_ff, dy4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ge4_ff  <= q3_ff >= fl3_ff;
         q4_ff   <= q3_ff;
         rem4_ff <= fl3_ff - q3_ff;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
      end
   end

   // square roots, with the transaction context delayed alongside
   logic [31:0] z_root, s_root;

   lik_sqrt u_sqrt_dist (
      .clock    (clock),
      .advance  (advance),
      .value_in (q4_ff),
      .root_out (z_root)
   );

   lik_sqrt u_sqrt_side (
      .clock    (clock),
      .advance  (advance),
      .value_in (rem4_ff),
      .root_out (s_root)
   );

   logic [SQ-1:0] sq_valid_ff;
   sq_ctx_type    sq_ctx_ff [SQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (advance) begin
         sq_valid_ff <= {sq_valid_ff[SQ-2:0], v4_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ctx_ff[0] <= '{dx: dx4_ff, dy: dy4_ff, ge: ge4_ff};
         for (int i = 1; i < SQ; i++) begin
            sq_ctx_ff[i] <= sq_ctx_ff[i-1];
         end
      end
   end

   // stage 5: reach flag, special angle cases, vectoring inputs
   sq_ctx_type           sq_tail;
   logic signed [32:0]   dx33, dy33, fx33, fy33;
   logic                 v5_ff;
   vc_ctx_type           ctx5_ff;
   logic signed [VW-1:0] fx5_ff, fy5_ff, zx5_ff, sy5_ff;
   ang_mode_type         a1_mode, a2_mode;

   assign sq_tail = sq_ctx_ff[SQ-1];
   assign dx33    = {sq_tail.dx[31], sq_tail.dx};
   assign dy33    = {sq_tail.dy[31], sq_tail.dy};
   assign fx33    = sq_tail.dx[31] ? -dx33 : dx33;
   assign fy33    = sq_tail.dx[31] ? -dy33 : dy33;

   always_comb begin
      if (sq_tail.dy == '0) begin
         a1_mode = ANG_ZERO;
      end else if (sq_tail.dx == '0) begin
         a1_mode = ANG_HALF;
      end else begin
         a1_mode = ANG_CORDIC;
      end
      if (sq_tail.ge || s_root == '0) begin
         a2_mode = ANG_ZERO;
      end else if (z_root == '0) begin
         a2_mode = ANG_HALF;
      end else begin
         a2_mode = ANG_CORDIC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= sq_valid_ff[SQ-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx5_ff.dx      <= sq_tail.dx;
         ctx5_ff.dy      <= sq_tail.dy;
         ctx5_ff.reach   <= 33'(z_root) < (33'(l1_ff) + 33'(l2_ff));
         ctx5_ff.a1_mode <= a1_mode;
         ctx5_ff.a2_mode <= a2_mode;
         fx5_ff          <= $signed({{(VW-33){fx33[32]}}, fx33});
         fy5_ff          <= $signed({{(VW-33){fy33[32]}}, fy33});
         zx5_ff          <= $signed({{(VW-32){1'b0}}, z_root});
         sy5_ff          <= $signed({{(VW-32){1'b0}}, s_root});
      end
   end

   // direction angle and elbow offset angle
   logic signed [AW-1:0] a1_ang, a2_ang;

   lik_vector u_vec_dir (
      .clock     (clock),
      .advance   (advance),
      .x_in      (fx5_ff),
      .y_in      (fy5_ff),
      .angle_out (a1_ang)
   );

   lik_vector u_vec_elbow (
      .clock     (clock),
      .advance   (advance),
      .x_in      (zx5_ff),
      .y_in      (sy5_ff),
      .angle_out (a2_ang)
   );

   logic [VL-1:0] vc_valid_ff;
   vc_ctx_type    vc_ctx_ff [VL];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_valid_ff <= '0;
      end else if (advance) begin
         vc_valid_ff <= {vc_valid_ff[VL-2:0], v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vc_ctx_ff[0] <= ctx5_ff;
         for (int i = 1; i < VL; i++) begin
            vc_ctx_ff[i] <= vc_ctx_ff[i-1];
         end
      end
   end

   // stage 6: fold the direction into [0, pi), clamp the offset to [0, pi/2]
   vc_ctx_type           vc_tail;
   logic                 v6_ff;
   logic signed [31:0]   dx6_ff, dy6_ff;
   logic                 reach6_ff;
   logic signed [AW-1:0] a1_in, a2_in, a1_6_ff, a2_6_ff;

   assign vc_tail = vc_ctx_ff[VL-1];

   always_comb begin
      case (vc_tail.a1_mode)
         ANG_ZERO:   a1_in = '0;
         ANG_HALF:   a1_in = lik_pkg::ANG_HALF_PI;
         ANG_CORDIC: a1_in = a1_ang[AW-1] ? a1_ang + lik_pkg::ANG_PI : a1_ang;
         default:    a1_in = '0;
      endcase
      case (vc_tail.a2_mode)
         ANG_ZERO: a2_in = '0;
         ANG_HALF: a2_in = lik_pkg::ANG_HALF_PI;
         ANG_CORDIC: begin
            if (a2_ang[AW-1]) begin
               a2_in = '0;
            end else if (a2_ang > lik_pkg::ANG_HALF_PI) begin
               a2_in = lik_pkg::ANG_HALF_PI;
            end else begin
               a2_in = a2_ang;
            end
         end
         default: a2_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= vc_valid_ff[VL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx6_ff    <= vc_tail.dx;
         dy6_ff    <= vc_tail.dy;
         reach6_ff <= vc_tail.reach;
         a1_6_ff   <= a1_in;
         a2_6_ff   <= a2_in;
      end
   end

   // stage 7: elbow angle into the rotation range, scaled start vector
   logic                 v7_ff;
   logic signed [AW-1:0] th_sum, th7_ff;
   logic                 flip7_ff;
   rot_ctx_type          ctx7;
   logic signed [31:0]   dx7_ff, dy7_ff;
   logic                 reach7_ff;
   logic [60:0]          l1_gain;
   logic signed [VW-1:0] x0_7_ff;

   assign th_sum  = rev_ff ? a1_6_ff - a2_6_ff : a1_6_ff + a2_6_ff;
   assign l1_gain = l1_ff * lik_pkg::GAIN_INV;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (advance) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (th_sum > lik_pkg::ANG_HALF_PI) begin
            th7_ff   <= th_sum - lik_pkg::ANG_PI;
            flip7_ff <= 1'b1;
         end else begin
            th7_ff   <= th_sum;
            flip7_ff <= 1'b0;
         end
         dx7_ff    <= dx6_ff;
         dy7_ff    <= dy6_ff;
         reach7_ff <= reach6_ff;
         x0_7_ff   <= $signed(VW'(l1_gain >> lik_pkg::FRAC_BITS));
      end
   end

   assign ctx7 = '{dx: dx7_ff, dy: dy7_ff, reach: reach7_ff, flip: flip7_ff};

   // rotation CORDIC, one iteration per stage
   logic [CS-1:0]        rot_valid_ff;
   rot_ctx_type          rot_ctx_ff [CS];
   logic signed [VW-1:0] rot_x_ff   [CS];
   logic signed [VW-1:0] rot_y_ff   [CS];
   logic signed [AW-1:0] rot_th_ff  [CS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff <= '0;
      end else if (advance) begin
         rot_valid_ff <= {rot_valid_ff[CS-2:0], v7_ff};
      end
   end

   for (genvar i = 0; i < CS; i++) begin : g_rot
      logic signed [VW-1:0] xi, yi;
      logic signed [AW-1:0] ti, step_ang;
      rot_ctx_type          ci;

      assign step_ang = $signed(AW'(lik_pkg::ATAN_TAB[i]));

      if (i == 0) begin : g_first
         assign xi = x0_7_ff;
         assign yi = '0;
         assign ti = th7_ff;
         assign ci = ctx7;
      end else begin : g_next
         assign xi = rot_x_ff[i-1];
         assign yi = rot_y_ff[i-1];
         assign ti = rot_th_ff[i-1];
         assign ci = rot_ctx_ff[i-1];
      end

      // turn toward the remaining angle
      always_ff @(posedge clock) begin
         if (advance) begin
            rot_ctx_ff[i] <= ci;
            if (!ti[AW-1]) begin
               rot_x_ff[i]  <= xi - (yi >>> i);
               rot_y_ff[i]  <= yi + (xi >>> i);
               rot_th_ff[i] <= ti - step_ang;
            end else begin
               rot_x_ff[i]  <= xi + (yi >>> i);
               rot_y_ff[i]  <= yi - (xi >>> i);
               rot_th_ff[i] <= ti + step_ang;
            end
         end
      end
   end

   // output register
   rot_ctx_type rot_tail;
   assign rot_tail = rot_ctx_ff[CS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rot_valid_ff[CS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.elbow_x   <= round_sat(rot_x_ff[CS-1], rot_tail.flip);
         rsp_data_ff.elbow_y   <= round_sat(rot_y_ff[CS-1], rot_tail.flip);
         rsp_data_ff.tip_x     <= rot_tail.dx;
         rsp_data_ff.tip_y     <= rot_tail.dy;
         rsp_data_ff.reachable <= rot_tail.reach;
      end
   end

   // offset angle stays within a quarter turn
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> (a2_6_ff >= 0) && (a2_6_ff <= lik_pkg::ANG_HALF_PI))
      else $error("elbow offset angle outside [0, pi/2]");

   // folded elbow angle is inside the rotation range
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> (th7_ff <= lik_pkg::ANG_HALF_PI) && (th7_ff >= -lik_pkg::ANG_HALF_PI))
      else $error("rotation angle outside [-pi/2, pi/2]");

   // a frozen pipeline keeps its transactions
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sq_valid_ff) && $stable(vc_valid_ff) && $stable(rot_valid_ff))
      else $error("transaction moved while the pipeline was held");

endmodule

/* tb/lik_checker.sv */
`timescale 1ns / 1ps
// Checker for the two-link arm inverse kinematics block: watches the request, result and register
// channels, predicts each result in fixed point and compares it field by field. Depends on lik_pkg.
module lik_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  lik_pkg::req_type       req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lik_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  lik_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data,
   output int                     errors,
   output int                     pending
);

   // shadow copy of the register file
   longint          base_x_q, base_y_q;
   longint unsigned len1_q, len2_q;
   bit              reversed_q;

   lik_pkg::rsp_type arm_queue[$];

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // angle of (x, y) with x >= 0, Q30 radians
   function automatic longint vector_angle(longint x, longint y);
      longint ang, xs, ys, ay;
      ang = 0;
      ay = (y < 0) ? -y : y;
      while (x < (64'sd1 <<< 46) && ay < (64'sd1 <<< 46)) begin
         x = x * 2;
         y = y * 2;
         ay = ay * 2;
      end
      for (int i = 0; i < lik_pkg::CORDIC_STAGES && i < 31; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; ang = ang + longint'(lik_pkg::ATAN_TAB[i]);
         end else begin
            x = x - ys; y = y + xs; ang = ang - longint'(lik_pkg::ATAN_TAB[i]);
         end
      end
      return ang;
   endfunction

   function automatic lik_pkg::rsp_type solve_arm(lik_pkg::req_type t);
      longint           dx, dy, fx, fy, a1, a2, th, x, y, xs, ys, api, ahalf;
      longint unsigned  q, z, reach_sq, s;
      bit               flip;
      lik_pkg::rsp_type r;
      api   = longint'(lik_pkg::ANG_PI);
      ahalf = longint'(lik_pkg::ANG_HALF_PI);
      dx = clamp32(longint'(t.target_x) - base_x_q);
      dy = clamp32(longint'(t.target_y) - base_y_q);
      q = unsigned'(dx * dx) + unsigned'(dy * dy);
      z = root64(q);
      reach_sq = (2 * len1_q) * (2 * len1_q);
      // direction folded into [0, pi)
      if (dy == 0) a1 = 0;
      else if (dx == 0) a1 = ahalf;
      else begin
         fx = dx; fy = dy;
         if (fx < 0) begin fx = -fx; fy = -fy; end
         a1 = vector_angle(fx, fy);
         if (a1 < 0) a1 = a1 + api;
      end
      // elbow offset angle
      if (q >= reach_sq) a2 = 0;
      else begin
         s = root64(reach_sq - q);
         if (s == 0) a2 = 0;
         else if (z == 0) a2 = ahalf;
         else a2 = vector_angle(longint'(z), longint'(s));
         if (a2 < 0) a2 = 0;
         if (a2 > ahalf) a2 = ahalf;
      end
      th = reversed_q ? a1 - a2 : a1 + a2;
      flip = 0;
      if (th > ahalf) begin th = th - api; flip = 1; end
      // rotate the pre-scaled first segment
      x = longint'((len1_q * 64'(lik_pkg::GAIN_INV)) >> 16);
      y = 0;
      for (int i = 0; i < lik_pkg::CORDIC_STAGES && i < 31; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (th >= 0) begin
            x = x - ys; y = y + xs; th = th - longint'(lik_pkg::ATAN_TAB[i]);
         end else begin
            x = x + ys; y = y - xs; th = th + longint'(lik_pkg::ATAN_TAB[i]);
         end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      if (flip) begin x = -x; y = -y; end
      r.elbow_x   = 32'(clamp32(x));
      r.elbow_y   = 32'(clamp32(y));
      r.tip_x     = 32'(dx);
      r.tip_y     = 32'(dy);
      r.reachable = (z < len1_q + len2_q);
      return r;
   endfunction

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
   endtask

   // track registers, predict on each accepted target, compare each result
   always @(posedge clock) begin
      lik_pkg::rsp_type want;
      if (reset) begin
         base_x_q   <= 0;
         base_y_q   <= 0;
         len1_q     <= 64'(lik_pkg::SEG_RESET);
         len2_q     <= 64'(lik_pkg::SEG_RESET);
         reversed_q <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lik_pkg::CSR_BASE_X:     base_x_q   <= longint'(signed'(csr_data));
               lik_pkg::CSR_BASE_Y:     base_y_q   <= longint'(signed'(csr_data));
               lik_pkg::CSR_FIRST_LEN:  len1_q     <= 64'(csr_data[30:0]);
               lik_pkg::CSR_SECOND_LEN: len2_q     <= 64'(csr_data[30:0]);
               lik_pkg::CSR_ELBOW_REV:  reversed_q <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            arm_queue.insert(arm_queue.size(), solve_arm(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (arm_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t unexpected result %h", $realtime, rsp_data);
            end else begin
               want = arm_queue.pop_front();
               if (want.elbow_x != rsp_data.elbow_x)
                  report_field("elbow_x", want.elbow_x, rsp_data.elbow_x);
               if (want.elbow_y != rsp_data.elbow_y)
                  report_field("elbow_y", want.elbow_y, rsp_data.elbow_y);
               if (want.tip_x != rsp_data.tip_x)
                  report_field("tip_x", want.tip_x, rsp_data.tip_x);
               if (want.tip_y != rsp_data.tip_y)
                  report_field("tip_y", want.tip_y, rsp_data.tip_y);
               if (want.reachable != rsp_data.reachable)
                  report_field("reachable", 32'(want.reachable), 32'(rsp_data.reachable));
            end
         end
      end
      pending = arm_queue.size();
   end

   initial begin
      errors  = 0;
      pending = 0;
   end

endmodule

/* tb/two_link_arm_inverse_kinematics_test.sv */
`timescale 1ns / 1ps
// Testbench top for the two-link arm inverse kinematics block: drives targets and register
// writes under random idling and gives the verdict. Depends on lik_pkg and lik_checker.
module two_link_arm_inverse_kinematics_test;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_stall;
   lik_pkg::req_type       req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 0;
   lik_pkg::rsp_type       rsp_data;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   lik_pkg::csr_index_type csr_index = lik_pkg::CSR_BASE_X;
   logic [31:0]            csr_data = '0;
   int                     errors, pending;
   int                     send_idle_pct = 0, take_idle_pct = 0;

   // shadow of the configuration used to aim targets near the arm
   logic [31:0]   aim_x = 0, aim_y = 0, aim_len = 32'h10000;

   always #2 clock = ~clock;

   two_link_arm_inverse_kinematics dut (.*);

   lik_checker check (.*);

   // random back-pressure on the result channel
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < take_idle_pct);

   task automatic write_reg(lik_pkg::csr_index_type idx, logic [31:0] val);
      bit done;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      done = 0;
      while (!done) begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 0;
      @(posedge clock);
      if (idx == lik_pkg::CSR_BASE_X) aim_x = val;
      if (idx == lik_pkg::CSR_BASE_Y) aim_y = val;
      if (idx == lik_pkg::CSR_FIRST_LEN) aim_len = {1'b0, val[30:0]};
   endtask

   // hold the target until taken, then maybe drop valid for a while
   task automatic send_target(logic [31:0] tx, logic [31:0] ty);
      bit done;
      req_valid <= 1;
      req_data  <= '{target_x: tx, target_y: ty};
      done = 0;
      while (!done) begin
         @(negedge clock);
         done = !req_stall;
         @(posedge clock);
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // let the pipeline drain before touching registers
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (90) @(posedge clock);
   endtask

   // aimed target: offset within a few first-segment lengths of the base
   task automatic send_near();
      longint span, ox, oy;
      span = (aim_len == 0) ? 64'd65536 : longint'(aim_len) * ($urandom_range(1, 3));
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      ox = longint'($urandom) % span - longint'($urandom) % span;
      oy = longint'($urandom) % span - longint'($urandom) % span;
      send_target(32'(longint'(signed'(aim_x)) + ox), 32'(longint'(signed'(aim_y)) + oy));
   endtask

   task automatic random_config(int pick);
      logic [31:0] len;
      drain();
      case (pick)
         0: len = 32'h7FFFFFFF;
         1: len = 0;
         default: len = 32'($urandom_range(32'h100, 32'h200000));
      endcase
      if (pick == 0) begin
         write_reg(lik_pkg::CSR_BASE_X, 32'h80000000);
         write_reg(lik_pkg::CSR_BASE_Y, 32'h7FFFFFFF);
      end else begin
         write_reg(lik_pkg::CSR_BASE_X,
                   $urandom_range(1) ? $urandom : $urandom_range(0, 32'h3FFFFF));
         write_reg(lik_pkg::CSR_BASE_Y,
                   $urandom_range(1) ? $urandom : $urandom_range(0, 32'h3FFFFF));
      end
      write_reg(lik_pkg::CSR_FIRST_LEN, {1'($urandom_range(1)), len[30:0]});
      write_reg(lik_pkg::CSR_SECOND_LEN, $urandom_range(3) == 0 ? 32'hFFFFFFFF : $urandom);
      write_reg(lik_pkg::CSR_ELBOW_REV, $urandom);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset registers, unit segments
      send_target(0, 0);
      send_target(0, 32'h00018000);
      send_target(0, 32'hFFFE0000);
      send_target(32'h00010000, 0);
      send_target(32'hFFFF0000, 0);
      send_target(32'hFFFF8000, 32'h00008000);
      send_target(32'h00008000, 32'hFFFF8000);
      send_target(32'h00020000, 0);
      send_target(32'h00010000, 32'h00010000);
      send_target(32'h7FFFFFFF, 32'h7FFFFFFF);
      send_target(32'h80000000, 32'h80000000);
      send_target(32'h80000000, 32'h7FFFFFFF);
      send_target(32'h00000001, 32'hFFFFFFFF);
      drain();
      write_reg(lik_pkg::CSR_ELBOW_REV, 1);
      send_target(32'h00004000, 32'h00006000);
      send_target(32'hFFFFC000, 32'hFFFFA000);
      send_target(0, 0);
      drain();
      // saturating offsets and a zero-length first segment
      write_reg(lik_pkg::CSR_BASE_X, 32'h7FFFFFFF);
      write_reg(lik_pkg::CSR_BASE_Y, 32'h80000000);
      write_reg(lik_pkg::CSR_FIRST_LEN, 0);
      write_reg(lik_pkg::CSR_SECOND_LEN, 32'h7FFFFFFF);
      write_reg(lik_pkg::CSR_ELBOW_REV, 0);
      send_target(32'h80000000, 32'h7FFFFFFF);
      send_target(32'h7FFFFFFF, 32'h80000000);
      send_target(0, 0);
      send_target(32'hFFFFFFFF, 32'h00000001);

      // random: three idling mixes, three register settings each
      for (int phase = 0; phase < 3; phase++) begin
         for (int set = 0; set < 3; set++) begin
            random_config(set);
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 88 : 0;
            take_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 24 : 0;
            for (int n = 0; n < 138; n++) begin
               if ($urandom_range(9) < 7) send_near();
               else send_target($urandom, $urandom);
               // hold off until every result is back
               if (n == 70 && set == 1) begin
                  req_valid <= 0;
                  @(posedge clock);
                  wait (pending == 0);
                  @(posedge clock);
               end
            end
         end
      end

      req_valid <= 0;
      wait (pending == 0);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("two_link_arm_inverse_kinematics: match");
      else
         $display("two_link_arm_inverse_kinematics: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("two_link_arm_inverse_kinematics: mismatch");
      $finish;
   end

endmodule
